// ===== rtl/humidity_temp_sensor_poller_assert.svh =====
// ----------------------------------------------------------------------------
// humidity_temp_sensor_poller assertion macros
// Shared concurrent assertion forms, sampled on clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_TEMP_SENSOR_POLLER_ASSERT_SVH
`define HUMIDITY_TEMP_SENSOR_POLLER_ASSERT_SVH

// same-cycle implication
`define HTSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("htsp assertion failed");

// next-cycle implication
`define HTSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("htsp assertion failed");

`endif

// ===== rtl/htsp_pkg.sv =====
// ----------------------------------------------------------------------------
// htsp_pkg
// Types and constants for the humidity/temperature sensor poller.
// ----------------------------------------------------------------------------
package htsp_pkg;

  typedef enum logic [2:0] {
    PH_POWERON = 3'd0,
    PH_SETUP   = 3'd1,
    PH_TRIGGER = 3'd2,
    PH_MEASURE = 3'd3,
    PH_WAIT    = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    CMD_NONE          = 3'd0,
    CMD_CLOSE_STOP    = 3'd1,
    CMD_WRITE_SETUP   = 3'd2,
    CMD_WRITE_TRIGGER = 3'd3,
    CMD_READ4         = 3'd4,
    CMD_STOP          = 3'd5,
    CMD_RESTART_READ  = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_DEVICE_ADDRESS  = 2'd0,
    CFG_SETUP_WORD      = 2'd1,
    CFG_TIMEOUT_SECONDS = 2'd2
  } cfg_idx_t;

  localparam int unsigned RAW_W    = 16;
  localparam int unsigned KELVIN_W = 9;
  localparam int unsigned HUM_W    = 7;
  localparam int unsigned STABLE_W = 8;
  localparam int unsigned TLOAD_W  = 8;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned PROD_W   = 24;

  localparam logic [7:0]          TEMP_SCALE    = 8'd165;
  localparam logic [7:0]          HUM_SCALE     = 8'd100;
  localparam logic [PROD_W-1:0]   ROUND_HALF    = 24'h008000;
  localparam logic [KELVIN_W-1:0] KELVIN_OFFSET = 9'd233;  // +273 - 40
  localparam logic [STABLE_W-1:0] STABLE_MAX    = 8'd255;
  localparam logic [TLOAD_W-1:0]  TIMEOUT_RESET = 8'd5;

endpackage

// ===== rtl/humidity_temp_sensor_poller.sv =====
// an accepted tick goes through the input register, then the result register
// one poll tick per cycle unless out_ready stalls; phase, samples load with the result
// the raw-word conversions run ahead of the input register, the phase step after it
// reset (rst_n low, synchronous): phase to power on, kelvin, humidity and stable count
// to zero, both stages empty, timeout to 5 seconds
// ----------------------------------------------------------------------------
// humidity_temp_sensor_poller
// Steps a bus-attached humidity/temperature sensor through its poll phases,
// issues at most one bus command per tick and converts good reads.
// ----------------------------------------------------------------------------
`include "humidity_temp_sensor_poller_assert.svh"

module humidity_temp_sensor_poller (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [htsp_pkg::CFG_W-1:0]     cfg_wdata,
  // poll tick channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_bus_done,
  input  logic                           in_bus_error,
  input  logic                           in_bus_nack,
  input  logic                           in_timer_expired,
  input  logic [htsp_pkg::RAW_W-1:0]     in_temp_raw,
  input  logic [htsp_pkg::RAW_W-1:0]     in_hum_raw,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     out_command,
  output logic [htsp_pkg::TLOAD_W-1:0]   out_timer_load,
  output logic [2:0]                     out_phase,
  output logic [htsp_pkg::KELVIN_W-1:0]  out_abs_temp_kelvin,
  output logic [htsp_pkg::HUM_W-1:0]     out_rel_humidity,
  output logic [htsp_pkg::STABLE_W-1:0]  out_stable_count,
  output logic                           out_new_sample
);
  import htsp_pkg::*;

  // only the timeout bears on results; address and setup word belong to the bus engine
  logic [TLOAD_W-1:0]  timeout_r;

  // input stage
  logic                s1_valid_r;
  logic                s1_done_r;
  logic                s1_err_r;
  logic                s1_nack_r;
  logic                s1_exp_r;
  logic [KELVIN_W-1:0] s1_kelvin_r;
  logic [HUM_W-1:0]    s1_hum_r;

  // result stage, which also holds the poller state
  logic                out_valid_r;
  cmd_t                cmd_r;
  logic [TLOAD_W-1:0]  tload_r;
  phase_t              phase_r;
  logic [KELVIN_W-1:0] kelvin_r;
  logic [HUM_W-1:0]    hum_r;
  logic [STABLE_W-1:0] stable_r;
  logic                fresh_r;

  logic                advance;
  logic                in_xfer;
  logic [PROD_W-1:0]   temp_sum;
  logic [PROD_W-1:0]   hum_sum;
  logic [KELVIN_W-1:0] kelvin_conv;

  cmd_t                cmd_nxt;
  logic [TLOAD_W-1:0]  tload_nxt;
  phase_t              phase_nxt;
  logic [KELVIN_W-1:0] kelvin_nxt;
  logic [HUM_W-1:0]    hum_nxt;
  logic [STABLE_W-1:0] stable_nxt;
  logic                fresh_nxt;
  logic                go;
  phase_t              tgt;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign in_xfer  = in_valid && in_ready;

  // fixed-point conversions, rounded to nearest
  assign temp_sum    = PROD_W'(in_temp_raw) * PROD_W'(TEMP_SCALE) + ROUND_HALF;
  assign hum_sum     = PROD_W'(in_hum_raw) * PROD_W'(HUM_SCALE) + ROUND_HALF;
  assign kelvin_conv = KELVIN_W'(temp_sum[PROD_W-1:16]) + KELVIN_OFFSET;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we && (cfg_index == CFG_TIMEOUT_SECONDS)) begin
      timeout_r <= cfg_wdata[TLOAD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_done_r   <= in_bus_done;
      s1_err_r    <= in_bus_error;
      s1_nack_r   <= in_bus_nack;
      s1_exp_r    <= in_timer_expired;
      s1_kelvin_r <= kelvin_conv;
      s1_hum_r    <= hum_sum[HUM_W+15:16];
    end
  end

  // one poll step
  always_comb begin
    cmd_nxt    = CMD_NONE;
    tload_nxt  = '0;
    phase_nxt  = phase_r;
    kelvin_nxt = kelvin_r;
    hum_nxt    = hum_r;
    stable_nxt = stable_r;
    fresh_nxt  = 1'b0;
    go         = 1'b0;
    tgt        = PH_POWERON;
    case (phase_r)
      PH_SETUP, PH_TRIGGER: begin
        if (s1_done_r) begin
          go = 1'b1;
          if (s1_err_r) begin
            tgt = PH_POWERON;
          end else if (phase_r == PH_SETUP) begin
            tgt = PH_TRIGGER;
          end else begin
            tgt = PH_MEASURE;
          end
        end else if (s1_exp_r) begin
          go = 1'b1;
        end
      end
      PH_MEASURE: begin
        if (s1_done_r) begin
          if (s1_nack_r) begin
            cmd_nxt = CMD_RESTART_READ;
          end else if (s1_err_r) begin
            go = 1'b1;
          end else begin
            go        = 1'b1;
            tgt       = PH_WAIT;
            fresh_nxt = 1'b1;
            hum_nxt   = s1_hum_r;
            if (s1_kelvin_r != kelvin_r) begin
              kelvin_nxt = s1_kelvin_r;
              stable_nxt = '0;
            end else if (stable_r != STABLE_MAX) begin
              stable_nxt = stable_r + 1'b1;
            end
          end
        end else if (s1_exp_r) begin
          go = 1'b1;
        end
      end
      PH_WAIT: begin
        if (s1_exp_r) begin
          go  = 1'b1;
          tgt = PH_TRIGGER;
        end
      end
      default: begin
        // power on, and any stray phase code
        stable_nxt = '0;
        go         = 1'b1;
        tgt        = PH_SETUP;
      end
    endcase
    // command and timer load that go with entering a phase
    if (go) begin
      phase_nxt = tgt;
      case (tgt)
        PH_SETUP: begin
          cmd_nxt   = CMD_WRITE_SETUP;
          tload_nxt = timeout_r;
        end
        PH_TRIGGER: begin
          cmd_nxt   = CMD_WRITE_TRIGGER;
          tload_nxt = timeout_r;
        end
        PH_MEASURE: cmd_nxt = CMD_READ4;
        PH_WAIT:    cmd_nxt = CMD_STOP;
        default:    cmd_nxt = CMD_CLOSE_STOP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= PH_POWERON;
      kelvin_r    <= '0;
      hum_r       <= '0;
      stable_r    <= '0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        phase_r  <= phase_nxt;
        kelvin_r <= kelvin_nxt;
        hum_r    <= hum_nxt;
        stable_r <= stable_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      cmd_r   <= cmd_nxt;
      tload_r <= tload_nxt;
      fresh_r <= fresh_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_command         = cmd_r;
  assign out_timer_load      = tload_r;
  assign out_phase           = phase_r;
  assign out_abs_temp_kelvin = kelvin_r;
  assign out_rel_humidity    = hum_r;
  assign out_stable_count    = stable_r;
  assign out_new_sample      = fresh_r;

  // a fresh sample always lands in the wait phase with a stop
  `HTSP_ASSERT_NOW(a_fresh_wait, out_valid_r && fresh_r,
    (phase_r == PH_WAIT) && (cmd_r == CMD_STOP))
  // timer starts only with setup and trigger writes
  `HTSP_ASSERT_NOW(a_tload_cmd, out_valid_r && (tload_r != '0),
    (cmd_r == CMD_WRITE_SETUP) || (cmd_r == CMD_WRITE_TRIGGER))
  // a full pipe under a stalled result takes no new tick
  `HTSP_ASSERT_NOW(a_full_stall, out_valid_r && !out_ready && s1_valid_r, !in_ready)
  // power on always moves to setup and clears the stable count
  `HTSP_ASSERT_NEXT(a_poweron_step, advance && s1_valid_r && (phase_r == PH_POWERON),
    (phase_r == PH_SETUP) && (stable_r == '0) && (cmd_r == CMD_WRITE_SETUP))

endmodule
